>>> src/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared widths, register indexes, configuration and result types for the
// servo slew limiter with endpoint guard.
// ----------------------------------------------------------------------------
package ssg_pkg;

   localparam int ANGLE_W    = 8;
   localparam int HOLD_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NEAR_DEG   = 3;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SET  = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_LIMIT    = 3'd0,
      CSR_RIGHT_LIMIT   = 3'd1,
      CSR_CENTER_ANGLE  = 3'd2,
      CSR_NORMAL_STEP   = 3'd3,
      CSR_RETURN_STEP   = 3'd4,
      CSR_ENDPOINT_STEP = 3'd5,
      CSR_RELIEF_ANGLE  = 3'd6,
      CSR_HOLD_UPDATES  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] left_limit;
      logic [ANGLE_W-1:0] right_limit;
      logic [ANGLE_W-1:0] center_angle;
      logic [ANGLE_W-1:0] normal_step;
      logic [ANGLE_W-1:0] return_step;
      logic [ANGLE_W-1:0] endpoint_step;
      logic [ANGLE_W-1:0] relief_angle;
      logic [HOLD_W-1:0]  hold_updates;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      left_limit:    8'd45,
      right_limit:   8'd135,
      center_angle:  8'd90,
      normal_step:   8'd2,
      return_step:   8'd4,
      endpoint_step: 8'd1,
      relief_angle:  8'd5,
      hold_updates:  16'd100
   };

   // angle that target and current take at reset
   localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;

   typedef struct packed {
      logic               status;
      logic               servo_write;
      logic [ANGLE_W-1:0] drive_angle;
      logic [ANGLE_W-1:0] target_now;
      logic               relief_flag;
   } rsp_type;

endpackage

>>> src/ssg_req_if.sv
// ----------------------------------------------------------------------------
// ssg_req_if
// Request channel: update tick or set-target word with valid/ready.
// ----------------------------------------------------------------------------
interface ssg_req_if
   import ssg_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [ANGLE_W-1:0] new_target;

   modport source (output valid, req_type, new_target, input ready);
   modport sink   (input valid, req_type, new_target, output ready);
endinterface

>>> src/ssg_rsp_if.sv
// ----------------------------------------------------------------------------
// ssg_rsp_if
// Response channel: status, servo drive and state report with valid/ready.
// ----------------------------------------------------------------------------
interface ssg_rsp_if
   import ssg_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               status;
   logic               servo_write;
   logic [ANGLE_W-1:0] drive_angle;
   logic [ANGLE_W-1:0] target_now;
   logic               relief_flag;

   modport source (output valid, status, servo_write, drive_angle, target_now,
                   relief_flag, input ready);
   modport sink   (input valid, status, servo_write, drive_angle, target_now,
                   relief_flag, output ready);
endinterface

>>> src/servo_slew_endpoint_guard.sv
// ----------------------------------------------------------------------------
// servo_slew_endpoint_guard
// Servo slew limiter with endpoint hold and relief, one response per word.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        req_type, new_target
//   rsp_chan  out   valid/ready        status, servo_write, drive_angle,
//                                      target_now, relief_flag
//   csr_*     in    csr_we             csr_index, csr_wdata
//
// One word per cycle sustained while responses are taken; a request passes the
// input register, then next-state logic into the response register. State
// updates when a word moves into the response register. Reset is synchronous
// and restores the valid flags, configuration and servo state; the data
// registers are not reset.
// A stalled response holds; the input register still takes one more word.
// ----------------------------------------------------------------------------
module servo_slew_endpoint_guard
   import ssg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ssg_req_if.sink               req_chan,
   ssg_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type result;

   logic               s1_valid_ff;
   logic               s1_type_ff;
   logic [ANGLE_W-1:0] s1_target_ff;
   logic               out_valid_ff;
   rsp_type            out_ff;
   logic               advance;
   logic               req_fire;

   ssg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fire       (advance),
      .req_type   (s1_type_ff),
      .new_target (s1_target_ff),
      .result     (result)
   );

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= req_fire || (s1_valid_ff && !advance);
         out_valid_ff <= advance || (out_valid_ff && !rsp_chan.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff   <= req_chan.req_type;
         s1_target_ff <= req_chan.new_target;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.servo_write = out_ff.servo_write;
   assign rsp_chan.drive_angle = out_ff.drive_angle;
   assign rsp_chan.target_now  = out_ff.target_now;
   assign rsp_chan.relief_flag = out_ff.relief_flag;

endmodule

>>> src/ssg_csr.sv
// ----------------------------------------------------------------------------
// ssg_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module ssg_csr
   import ssg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LEFT_LIMIT:    cfg_in.left_limit    = csr_wdata[ANGLE_W-1:0];
            CSR_RIGHT_LIMIT:   cfg_in.right_limit   = csr_wdata[ANGLE_W-1:0];
            CSR_CENTER_ANGLE:  cfg_in.center_angle  = csr_wdata[ANGLE_W-1:0];
            CSR_NORMAL_STEP:   cfg_in.normal_step   = csr_wdata[ANGLE_W-1:0];
            CSR_RETURN_STEP:   cfg_in.return_step   = csr_wdata[ANGLE_W-1:0];
            CSR_ENDPOINT_STEP: cfg_in.endpoint_step = csr_wdata[ANGLE_W-1:0];
            CSR_RELIEF_ANGLE:  cfg_in.relief_angle  = csr_wdata[ANGLE_W-1:0];
            CSR_HOLD_UPDATES:  cfg_in.hold_updates  = csr_wdata[HOLD_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/ssg_core.sv
// ----------------------------------------------------------------------------
// ssg_core
// Servo state (target, current, hold timer, flags) and the single-pass
// next-state logic for one set-target or update-tick word.
// ----------------------------------------------------------------------------
module ssg_core
   import ssg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               fire,
   input  logic               req_type,
   input  logic [ANGLE_W-1:0] new_target,
   output rsp_type            result
);

   localparam logic [ANGLE_W+1:0] NEAR_EXT = (ANGLE_W+2)'(NEAR_DEG);

   logic [ANGLE_W-1:0] target_ff, target_in;
   logic [ANGLE_W-1:0] current_ff, current_in;
   logic               returning_ff, returning_in;
   logic               armed_ff, armed_in;
   logic [HOLD_W-1:0]  elapsed_ff, elapsed_in;
   logic               relief_ff, relief_in;

   function automatic logic near_left(input logic [ANGLE_W-1:0] a,
                                      input logic [ANGLE_W-1:0] lim);
      return {2'b00, a} <= ({2'b00, lim} + NEAR_EXT);
   endfunction

   // a >= lim - 3 written without going negative
   function automatic logic near_right(input logic [ANGLE_W-1:0] a,
                                       input logic [ANGLE_W-1:0] lim);
      return ({2'b00, a} + NEAR_EXT) >= {2'b00, lim};
   endfunction

   // endpoint protection on the current target
   logic               pt_near_l, pt_near_r;
   logic [HOLD_W-1:0]  elapsed_inc;
   logic [ANGLE_W:0]   relief_sum;
   logic [ANGLE_W-1:0] relief_l, relief_r;
   logic [ANGLE_W-1:0] t_target;
   logic               t_armed, t_relief;
   logic [HOLD_W-1:0]  t_elapsed;

   assign pt_near_l   = near_left(target_ff, cfg.left_limit);
   assign pt_near_r   = near_right(target_ff, cfg.right_limit);
   assign elapsed_inc = (elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign relief_sum  = {1'b0, cfg.left_limit} + {1'b0, cfg.relief_angle};
   assign relief_l    = relief_sum[ANGLE_W] ? '1 : relief_sum[ANGLE_W-1:0];
   assign relief_r    = (cfg.right_limit >= cfg.relief_angle) ?
                        cfg.right_limit - cfg.relief_angle : '0;

   always_comb begin
      t_target  = target_ff;
      t_armed   = armed_ff;
      t_elapsed = elapsed_ff;
      t_relief  = relief_ff;
      if (!(pt_near_l || pt_near_r)) begin
         t_armed = 1'b0;
      end else if (!armed_ff) begin
         t_armed   = 1'b1;
         t_elapsed = '0;
      end else begin
         t_elapsed = elapsed_inc;
         if (elapsed_inc >= cfg.hold_updates) begin
            t_target = pt_near_l ? relief_l : relief_r;
            t_armed  = 1'b0;
            t_relief = 1'b1;
         end
      end
   end

   // slew toward the protected target
   logic [ANGLE_W-1:0] step;
   logic [ANGLE_W:0]   cur_up;
   logic [ANGLE_W:0]   floor_sum;
   logic [ANGLE_W-1:0] t_current;

   always_comb begin
      if (returning_ff) begin
         step = cfg.return_step;
      end else if (near_left(t_target, cfg.left_limit) ||
                   near_right(t_target, cfg.right_limit)) begin
         step = cfg.endpoint_step;
      end else begin
         step = cfg.normal_step;
      end
   end

   assign cur_up    = {1'b0, current_ff} + {1'b0, step};
   assign floor_sum = {1'b0, t_target} + {1'b0, step};

   always_comb begin
      if (current_ff < t_target) begin
         t_current = (cur_up > {1'b0, t_target}) ? t_target : cur_up[ANGLE_W-1:0];
      end else if (current_ff > t_target) begin
         // current - step below target clamps at target
         t_current = ({1'b0, current_ff} < floor_sum) ? t_target : current_ff - step;
      end else begin
         t_current = current_ff;
      end
   end

   // set-target checks
   logic in_range;
   logic set_near;

   assign in_range = (new_target >= cfg.left_limit) && (new_target <= cfg.right_limit);
   assign set_near = near_left(new_target, cfg.left_limit) ||
                     near_right(new_target, cfg.right_limit);

   always_comb begin
      target_in    = target_ff;
      current_in   = current_ff;
      returning_in = returning_ff;
      armed_in     = armed_ff;
      elapsed_in   = elapsed_ff;
      relief_in    = relief_ff;
      if (req_type == REQ_SET) begin
         if (in_range) begin
            target_in    = new_target;
            returning_in = (new_target == cfg.center_angle);
            relief_in    = 1'b0;
            if (!set_near) begin
               armed_in = 1'b0;
            end
         end
      end else begin
         target_in    = t_target;
         current_in   = t_current;
         armed_in     = t_armed;
         elapsed_in   = t_elapsed;
         relief_in    = t_relief;
         returning_in = returning_ff && (t_current != t_target);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= ANGLE_RESET;
         current_ff   <= ANGLE_RESET;
         returning_ff <= 1'b0;
         armed_ff     <= 1'b0;
         elapsed_ff   <= '0;
         relief_ff    <= 1'b0;
      end else if (fire) begin
         target_ff    <= target_in;
         current_ff   <= current_in;
         returning_ff <= returning_in;
         armed_ff     <= armed_in;
         elapsed_ff   <= elapsed_in;
         relief_ff    <= relief_in;
      end
   end

   always_comb begin
      result.status      = (req_type == REQ_SET && !in_range) ? STATUS_RANGE : STATUS_OK;
      result.servo_write = (req_type == REQ_TICK);
      result.drive_angle = current_in;
      result.target_now  = target_in;
      result.relief_flag = relief_in;
   end

endmodule

>>> src/ssg_checker.sv
// ----------------------------------------------------------------------------
// ssg_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module ssg_checker
   import ssg_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               status,
   input logic               servo_write,
   input logic [ANGLE_W-1:0] drive_angle,
   input logic [ANGLE_W-1:0] target_now,
   input logic               relief_flag
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({status, servo_write, drive_angle, target_now, relief_flag}))
      else $error("response changed while stalled");

   // a tick never reports a range error
   a_tick_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && servo_write |-> status == STATUS_OK)
      else $error("tick response with range error");

   // an accepted set-target clears relief
   a_set_clears_relief: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !servo_write && status == STATUS_OK |-> !relief_flag)
      else $error("relief flag set after accepted target");

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind servo_slew_endpoint_guard ssg_checker u_ssg_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .status      (rsp_chan.status),
   .servo_write (rsp_chan.servo_write),
   .drive_angle (rsp_chan.drive_angle),
   .target_now  (rsp_chan.target_now),
   .relief_flag (rsp_chan.relief_flag)
);
